### rtl/sfs_pkg.sv
// sfs_pkg: shared types, codes and constants for the staggered fermion stencil.
// Used by every module under rtl except sfs_ram; depends on nothing.
package sfs_pkg;

	// Default lattice extent
	localparam int LATTICE_T_DEF = 64;
	localparam int LATTICE_X_DEF = 64;

	// Field widths
	localparam int IDX_W   = 6;
	localparam int PSI_W   = 32;
	localparam int EXP_W   = 31;
	localparam int ENTRY_W = PSI_W + 3;   // psi, occupied, time eta, space eta
	localparam int CIDX_W  = 3;

	// Entry layout in the site store
	localparam int E_OCC   = PSI_W;
	localparam int E_ETA_T = PSI_W + 1;
	localparam int E_ETA_X = PSI_W + 2;

	// Arithmetic widths: one rounded term, and the sum of five of them
	localparam int PROD_W = 64;
	localparam int TERM_W = 40;
	localparam int ACC_W  = 42;

	// 1.0 in Q8.24
	localparam logic [PSI_W-1:0] Q_ONE = 32'h0100_0000;

	// Result queue depth
	localparam int RQ_DEPTH = 4;

	// Commands
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_MASS         = 3'd0,
		REG_EXP_FORWARD  = 3'd1,
		REG_EXP_BACKWARD = 3'd2,
		REG_TRANSPOSE    = 3'd3,
		REG_ANTIPERIODIC = 3'd4
	} reg_idx_t;

	// Read phase of a compute item: centre then the four neighbours
	typedef enum logic [4:0] {
		PH_CENTRE = 5'b00001,
		PH_T_UP   = 5'b00010,
		PH_T_DN   = 5'b00100,
		PH_X_UP   = 5'b01000,
		PH_X_DN   = 5'b10000
	} phase_t;

	// Configuration as seen by the sequencer
	typedef struct packed {
		logic [PSI_W-1:0] mass;
		logic [EXP_W-1:0] exp_forward;
		logic [EXP_W-1:0] exp_backward;
		logic             transpose;
		logic             antiperiodic;
	} cfg_t;

	// Per-read tag travelling alongside the memory read
	typedef struct packed {
		logic             centre;
		logic             last;
		logic             axis_t;
		logic             neg_base;
		logic [PSI_W-1:0] weight;
	} tag_t;

endpackage

### rtl/sfs_ram.sv
// sfs_ram: generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module sfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/sfs_seq.sv
// sfs_seq: takes items, writes loads to the site store and issues the five reads
// of a compute item with a tag per read. Depends on sfs_pkg.
module sfs_seq #(
	parameter int LATTICE_T = sfs_pkg::LATTICE_T_DEF,
	parameter int LATTICE_X = sfs_pkg::LATTICE_X_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   take,
	output logic                                   front_ready,
	input  logic                                   cmd,
	input  logic [sfs_pkg::IDX_W-1:0]              time_index,
	input  logic [sfs_pkg::IDX_W-1:0]              space_index,
	input  logic [sfs_pkg::PSI_W-1:0]              psi_value,
	input  logic                                   occupied,
	input  logic                                   time_sign,
	input  logic                                   space_sign,
	input  sfs_pkg::cfg_t                          cfg,
	output logic                                   mem_we,
	output logic                                   mem_re,
	output logic [$clog2(LATTICE_T*LATTICE_X)-1:0] mem_addr,
	output logic [sfs_pkg::ENTRY_W-1:0]            mem_wdata,
	output logic                                   iss_valid,
	output sfs_pkg::tag_t                          iss_tag
);

	localparam int TW    = $clog2(LATTICE_T);
	localparam int XW    = $clog2(LATTICE_X);
	localparam int AW    = $clog2(LATTICE_T * LATTICE_X);
	localparam int IDX_N = 1 << sfs_pkg::IDX_W;
	localparam logic [TW-1:0] T_LAST = TW'(LATTICE_T - 1);
	localparam logic [XW-1:0] X_LAST = XW'(LATTICE_X - 1);
	localparam logic [AW-1:0] X_ROW  = AW'(LATTICE_X);

	// Coordinate reduction tables, worked out at elaboration
	logic [TW-1:0] t_tab [IDX_N];
	logic [XW-1:0] x_tab [IDX_N];

	for (genvar i = 0; i < IDX_N; i++) begin : g_tab
		localparam int TM = i % LATTICE_T;
		localparam int XM = i % LATTICE_X;
		assign t_tab[i] = TW'(TM);
		assign x_tab[i] = XW'(XM);
	end

	logic                     busy_q;
	logic                     cmd_q;
	sfs_pkg::phase_t          phase_q;
	sfs_pkg::phase_t          phase_nxt;
	logic [TW-1:0]            t_q;
	logic [XW-1:0]            x_q;
	logic [sfs_pkg::PSI_W-1:0] psi_q;
	logic                     occ_q;
	logic [1:0]               ph_q;

	logic                     item_done;
	logic [TW-1:0]            t_up, t_dn, row;
	logic [XW-1:0]            x_up, x_dn, col;
	logic                     wrap_tu, wrap_td, wrap_xu, wrap_xd;

	assign item_done   = busy_q && ((cmd_q == sfs_pkg::CMD_LOAD) || (phase_q == sfs_pkg::PH_X_DN));
	assign front_ready = !busy_q || item_done;

	// Control: busy flag and read phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= sfs_pkg::PH_CENTRE;
		end else if (take) begin
			busy_q  <= 1'b1;
			phase_q <= sfs_pkg::PH_CENTRE;
		end else if (item_done) begin
			busy_q  <= 1'b0;
		end else if (busy_q) begin
			phase_q <= phase_nxt;
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
			t_q   <= t_tab[time_index];
			x_q   <= x_tab[space_index];
			psi_q <= psi_value;
			occ_q <= occupied;
			ph_q  <= {space_sign, time_sign};
		end
	end

	always_comb begin
		unique case (phase_q)
			sfs_pkg::PH_CENTRE: phase_nxt = sfs_pkg::PH_T_UP;
			sfs_pkg::PH_T_UP:   phase_nxt = sfs_pkg::PH_T_DN;
			sfs_pkg::PH_T_DN:   phase_nxt = sfs_pkg::PH_X_UP;
			sfs_pkg::PH_X_UP:   phase_nxt = sfs_pkg::PH_X_DN;
			default:            phase_nxt = sfs_pkg::PH_CENTRE;
		endcase
	end

	// Periodic neighbours and wrap marks
	assign wrap_tu = (t_q == T_LAST);
	assign wrap_td = (t_q == '0);
	assign wrap_xu = (x_q == X_LAST);
	assign wrap_xd = (x_q == '0);
	assign t_up    = wrap_tu ? '0 : TW'(t_q + TW'(1));
	assign t_dn    = wrap_td ? T_LAST : TW'(t_q - TW'(1));
	assign x_up    = wrap_xu ? '0 : XW'(x_q + XW'(1));
	assign x_dn    = wrap_xd ? X_LAST : XW'(x_q - XW'(1));

	// Per-phase address, weight and base sign (negative when set)
	always_comb begin
		iss_tag.centre = (phase_q == sfs_pkg::PH_CENTRE);
		iss_tag.last   = (phase_q == sfs_pkg::PH_X_DN);
		iss_tag.axis_t = 1'b0;
		unique case (phase_q)
			sfs_pkg::PH_CENTRE: begin
				row              = t_q;
				col              = x_q;
				iss_tag.neg_base = 1'b0;
				iss_tag.weight   = cfg.mass;
			end
			sfs_pkg::PH_T_UP: begin
				row              = t_up;
				col              = x_q;
				iss_tag.axis_t   = 1'b1;
				iss_tag.neg_base = cfg.transpose ^ (cfg.antiperiodic & wrap_tu);
				iss_tag.weight   = {1'b0, cfg.transpose ? cfg.exp_backward : cfg.exp_forward};
			end
			sfs_pkg::PH_T_DN: begin
				row              = t_dn;
				col              = x_q;
				iss_tag.axis_t   = 1'b1;
				iss_tag.neg_base = ~cfg.transpose ^ (cfg.antiperiodic & wrap_td);
				iss_tag.weight   = {1'b0, cfg.transpose ? cfg.exp_forward : cfg.exp_backward};
			end
			sfs_pkg::PH_X_UP: begin
				row              = t_q;
				col              = x_up;
				iss_tag.neg_base = cfg.transpose ^ (cfg.antiperiodic & wrap_xu);
				iss_tag.weight   = sfs_pkg::Q_ONE;
			end
			default: begin
				row              = t_q;
				col              = x_dn;
				iss_tag.neg_base = ~cfg.transpose ^ (cfg.antiperiodic & wrap_xd);
				iss_tag.weight   = sfs_pkg::Q_ONE;
			end
		endcase
	end

	// Store access: site = t * LATTICE_X + x
	assign mem_addr  = AW'(AW'(row) * X_ROW) + AW'(col);
	assign mem_we    = busy_q && (cmd_q == sfs_pkg::CMD_LOAD);
	assign mem_re    = busy_q && (cmd_q == sfs_pkg::CMD_COMPUTE);
	assign mem_wdata = {ph_q, occ_q, psi_q};
	assign iss_valid = mem_re;

endmodule

### rtl/sfs_dp.sv
// sfs_dp: multiply, round, sign and accumulate the five terms of a compute item,
// then saturate. Takes read data in the cycle after issue. Depends on sfs_pkg.
module sfs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        iss_valid,
	input  sfs_pkg::tag_t               iss_tag,
	input  logic [sfs_pkg::ENTRY_W-1:0] rd_data,
	output logic                        res_valid,
	output logic [sfs_pkg::PSI_W-1:0]   res_chi,
	output logic                        res_sat
);

	localparam int PW = sfs_pkg::PSI_W;
	localparam logic signed [sfs_pkg::ACC_W-1:0] CHI_MAX =
		{{(sfs_pkg::ACC_W-PW){1'b0}}, 1'b0, {(PW-1){1'b1}}};
	localparam logic signed [sfs_pkg::ACC_W-1:0] CHI_MIN =
		{{(sfs_pkg::ACC_W-PW){1'b1}}, 1'b1, {(PW-1){1'b0}}};
	localparam logic signed [sfs_pkg::PROD_W-1:0] RND_MASS = 64'sd8388608;
	localparam logic signed [sfs_pkg::PROD_W-1:0] RND_HOP  = 64'sd16777216;

	// s1: read data arrives
	logic           v_s1;
	sfs_pkg::tag_t  tag_s1;
	logic [1:0]     eta_q;
	logic           cen_occ_q;
	logic signed [PW-1:0] psi_m, weight_m;
	logic           neg_m;
	logic           occ_rd;

	// s2: product
	logic           v_s2, centre_s2, last_s2, neg_s2;
	logic signed [sfs_pkg::PROD_W-1:0] prod_s2;
	logic signed [sfs_pkg::PROD_W-1:0] rnd;
	logic signed [sfs_pkg::TERM_W-1:0] term;

	// s3: signed term
	logic           v_s3, centre_s3, last_s3;
	logic signed [sfs_pkg::TERM_W-1:0] term_s3;
	logic signed [sfs_pkg::ACC_W-1:0]  term_ext, acc_q, sum;

	// s4: full sum
	logic           v_s4;
	logic signed [sfs_pkg::ACC_W-1:0]  sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && last_s3;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss_tag;
	end

	// Centre entry: keep its phases and occupancy for the neighbour reads
	assign occ_rd = rd_data[sfs_pkg::E_OCC];

	always_ff @(posedge clk) begin
		if (v_s1 && tag_s1.centre) begin
			eta_q     <= {rd_data[sfs_pkg::E_ETA_X], rd_data[sfs_pkg::E_ETA_T]};
			cen_occ_q <= occ_rd;
		end
	end

	// Operand selection. An occupied centre passes psi through as psi * 1.0;
	// occupied neighbours, and all neighbours of an occupied centre, add nothing.
	always_comb begin
		if (tag_s1.centre) begin
			psi_m    = rd_data[PW-1:0];
			weight_m = occ_rd ? sfs_pkg::Q_ONE : tag_s1.weight;
			neg_m    = 1'b0;
		end else begin
			psi_m    = (occ_rd || cen_occ_q) ? '0 : rd_data[PW-1:0];
			weight_m = tag_s1.weight;
			neg_m    = tag_s1.neg_base ^ (tag_s1.axis_t ? eta_q[0] : eta_q[1]);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2   <= weight_m * psi_m;
		centre_s2 <= tag_s1.centre;
		last_s2   <= tag_s1.last;
		neg_s2    <= neg_m;
	end

	// Round half up: mass term by 2^-24, hops by 0.5 * 2^-24
	always_comb begin
		if (centre_s2) begin
			rnd = (prod_s2 + RND_MASS) >>> 24;
		end else begin
			rnd = (prod_s2 + RND_HOP) >>> 25;
		end
		term = rnd[sfs_pkg::TERM_W-1:0];
		if (neg_s2) begin
			term = -term;
		end
	end

	always_ff @(posedge clk) begin
		term_s3   <= term;
		centre_s3 <= centre_s2;
		last_s3   <= last_s2;
	end

	// Accumulate; the centre term opens a new sum
	assign term_ext = {{(sfs_pkg::ACC_W-sfs_pkg::TERM_W){term_s3[sfs_pkg::TERM_W-1]}}, term_s3};
	assign sum      = acc_q + term_ext;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			acc_q <= centre_s3 ? term_ext : sum;
		end
		if (v_s3 && last_s3) begin
			sum_s4 <= sum;
		end
	end

	// Saturate to 32 bits
	always_comb begin
		res_valid = v_s4;
		res_sat   = 1'b0;
		res_chi   = sum_s4[PW-1:0];
		if (sum_s4 > CHI_MAX) begin
			res_chi = CHI_MAX[PW-1:0];
			res_sat = 1'b1;
		end else if (sum_s4 < CHI_MIN) begin
			res_chi = CHI_MIN[PW-1:0];
			res_sat = 1'b1;
		end
	end

endmodule

### rtl/sfs_resq.sv
// sfs_resq: result queue in front of the output channel, with a credit count that
// bounds compute items in flight to the queue depth. Depends on sfs_pkg.
module sfs_resq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take_compute,
	output logic                      space,
	input  logic                      push,
	input  logic [sfs_pkg::PSI_W-1:0] push_chi,
	input  logic                      push_sat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sfs_pkg::PSI_W-1:0] chi_value,
	output logic                      saturated
);

	localparam int DEPTH = sfs_pkg::RQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [sfs_pkg::PSI_W:0] fifo_q [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]        cnt_q, credit_q;
	logic                    pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign space     = (credit_q < CNT_W'(DEPTH));
	assign chi_value = fifo_q[rd_ptr_q][sfs_pkg::PSI_W-1:0];
	assign saturated = fifo_q[rd_ptr_q][sfs_pkg::PSI_W];

	// Pointers, fill and credit counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(1));
			end
			if (pop) begin
				rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(1));
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
				2'b01:   cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
				default: cnt_q <= cnt_q;
			endcase
			unique case ({take_compute, pop})
				2'b10:   credit_q <= CNT_W'(credit_q + CNT_W'(1));
				2'b01:   credit_q <= CNT_W'(credit_q - CNT_W'(1));
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= {push_sat, push_chi};
		end
	end

endmodule

### rtl/staggered_fermion_stencil.sv
// Staggered fermion stencil on a periodic LATTICE_T x LATTICE_X lattice, one site store.
// Load item: written to the store. Compute item: one store read each (centre, t+1, t-1,
// x+1, x-1) through the single read port, and the next item is taken with the last read.
// Loads may follow every cycle while no compute runs and the result queue has credit.
// Reset clears control and sets the registers to mass 1.0, both exponentials 1.0,
// transpose off, antiperiodic on; the store holds no data until sites are loaded.
module staggered_fermion_stencil #(
	parameter int LATTICE_T = sfs_pkg::LATTICE_T_DEF,
	parameter int LATTICE_X = sfs_pkg::LATTICE_X_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sfs_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [sfs_pkg::PSI_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [sfs_pkg::IDX_W-1:0]   time_index,
	input  logic [sfs_pkg::IDX_W-1:0]   space_index,
	input  logic signed [sfs_pkg::PSI_W-1:0] psi_value,
	input  logic                        occupied,
	input  logic                        time_sign,
	input  logic                        space_sign,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [sfs_pkg::PSI_W-1:0] chi_value,
	output logic                        saturated
);

	localparam int DEPTH = LATTICE_T * LATTICE_X;
	localparam int AW    = $clog2(DEPTH);

	sfs_pkg::cfg_t               cfg_q;
	logic                        front_ready, space, take;
	logic                        mem_we, mem_re;
	logic [AW-1:0]               mem_addr;
	logic [sfs_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;
	logic                        iss_valid;
	sfs_pkg::tag_t               iss_tag;
	logic                        res_valid, res_sat;
	logic [sfs_pkg::PSI_W-1:0]   res_chi, chi_raw;

	assign cfg_ready = 1'b1;
	assign in_ready  = front_ready && space;
	assign take      = in_valid && in_ready;
	assign chi_value = chi_raw;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mass         <= sfs_pkg::Q_ONE;
			cfg_q.exp_forward  <= sfs_pkg::Q_ONE[sfs_pkg::EXP_W-1:0];
			cfg_q.exp_backward <= sfs_pkg::Q_ONE[sfs_pkg::EXP_W-1:0];
			cfg_q.transpose    <= 1'b0;
			cfg_q.antiperiodic <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sfs_pkg::reg_idx_t'(cfg_index))
				sfs_pkg::REG_MASS:         cfg_q.mass         <= cfg_data;
				sfs_pkg::REG_EXP_FORWARD:  cfg_q.exp_forward  <= cfg_data[sfs_pkg::EXP_W-1:0];
				sfs_pkg::REG_EXP_BACKWARD: cfg_q.exp_backward <= cfg_data[sfs_pkg::EXP_W-1:0];
				sfs_pkg::REG_TRANSPOSE:    cfg_q.transpose    <= cfg_data[0];
				sfs_pkg::REG_ANTIPERIODIC: cfg_q.antiperiodic <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sfs_seq #(
		.LATTICE_T(LATTICE_T),
		.LATTICE_X(LATTICE_X)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.front_ready (front_ready),
		.cmd         (cmd),
		.time_index  (time_index),
		.space_index (space_index),
		.psi_value   (psi_value),
		.occupied    (occupied),
		.time_sign   (time_sign),
		.space_sign  (space_sign),
		.cfg         (cfg_q),
		.mem_we      (mem_we),
		.mem_re      (mem_re),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.iss_valid   (iss_valid),
		.iss_tag     (iss_tag)
	);

	// Site store: psi, occupancy and both staggered phases per site
	sfs_ram #(
		.WIDTH(sfs_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	sfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss_valid (iss_valid),
		.iss_tag   (iss_tag),
		.rd_data   (mem_rdata),
		.res_valid (res_valid),
		.res_chi   (res_chi),
		.res_sat   (res_sat)
	);

	sfs_resq u_resq (
		.clk          (clk),
		.arst_n       (arst_n),
		.take_compute (take && (cmd == sfs_pkg::CMD_COMPUTE)),
		.space        (space),
		.push         (res_valid),
		.push_chi     (res_chi),
		.push_sat     (res_sat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chi_value    (chi_raw),
		.saturated    (saturated)
	);

endmodule
